// ===== rtl/dwcd_pkg.sv =====
`timescale 1ns / 1ps
// dwcd_pkg: shared types and constants of the debounce with chatter detection block
// used by every module in rtl; depends on nothing

package dwcd_pkg;

    localparam int TIME_W  = 40;
    localparam int WORD_W  = 32;
    localparam int CFG_W   = 16;
    localparam int CNT_W   = 4;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam int REJECT_THRESHOLD_DEF = 4;

    localparam logic [CFG_W-1:0] SAMPLE_PERIOD_RST = 16'd10;
    localparam logic [CFG_W-1:0] DEBOUNCE_RST      = 16'd50;
    localparam logic [CFG_W-1:0] WINDOW_RST        = 16'd1000;
    localparam logic [CFG_W-1:0] HOLD_RST          = 16'd5000;

    localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE      = 2'd1;
    localparam logic [1:0] REG_WINDOW        = 2'd2;
    localparam logic [1:0] REG_HOLD          = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_COUNT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              level_in;
        logic [TIME_W-1:0] now_ms;
    } sample_t;

    typedef struct packed {
        logic              stable_level;
        logic              raw_toggle;
        logic              pulse_dropped;
        logic              chatter_begun;
        logic              level_changed;
        logic              chattering;
        logic [TIME_W-1:0] transition_age_ms;
        logic [CNT_W-1:0]  rejections_in_window;
        logic [WORD_W-1:0] last_reject_width_ms;
        logic [WORD_W-1:0] accepted_count;
        logic [WORD_W-1:0] rejected_count;
        logic [WORD_W-1:0] chatter_count;
    } result_t;

    // count token walking the cell row
    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] left;
        logic [CNT_W-1:0] hits;
    } tok_t;

endpackage

// ===== rtl/dwcd_cell.sv =====
`timescale 1ns / 1ps
// dwcd_cell: one rejection timestamp slot of the cell row, with its window compare
// depends on dwcd_pkg

module dwcd_cell
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        shift,
    input  logic [dwcd_pkg::TIME_W-1:0] t_in,
    output logic [dwcd_pkg::TIME_W-1:0] t_out,
    input  dwcd_pkg::tok_t              tok_in,
    output dwcd_pkg::tok_t              tok_out,
    input  logic [dwcd_pkg::TIME_W-1:0] now,
    input  logic [dwcd_pkg::CFG_W-1:0]  window
);

    logic [dwcd_pkg::TIME_W-1:0] t_reg;
    logic [dwcd_pkg::TIME_W-1:0] diff;
    logic                        hit;
    dwcd_pkg::tok_t              tok_reg;
    dwcd_pkg::tok_t              tok_next;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            t_reg <= t_in;
        end
    end

    assign diff = now - t_reg;
    assign hit  = (tok_in.left != '0) && (now >= t_reg)
                  && (diff <= dwcd_pkg::TIME_W'(window));

    always_comb
    begin
        tok_next.valid = tok_in.valid;
        tok_next.left  = (tok_in.left != '0) ? tok_in.left - 1'b1 : tok_in.left;
        tok_next.hits  = tok_in.hits + dwcd_pkg::CNT_W'(hit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign t_out   = t_reg;
    assign tok_out = tok_reg;

endmodule

// ===== rtl/debounce_with_chatter_detect.sv =====
`timescale 1ns / 1ps
// debounce_with_chatter_detect: top level, register port, sequencer and the cell row
// depends on dwcd_pkg and dwcd_cell
//
//  channel   signals                            beat
//  sample    sample_valid, sample_stall, sample level and uptime in, one per sample
//  result    result_valid, result_stall, result debounced state and counters out
//  apb       psel, penable, pwrite, paddr ...   four 16 bit registers at 0x0..0xc
//
// a sample is taken in ST_IDLE, then passes ST_EVAL and ST_OUT, where its result is registered
// a sample that ends a rejected pulse also passes ST_COUNT between ST_EVAL and ST_OUT, while
// the count token walks the row of timestamp cells, one cell a cycle
// sample_stall is high while a sample is being worked on
// a finished beat waits in the result register; the next sample is taken meanwhile
// reset clears all control state and loads the register defaults

module debounce_with_chatter_detect
#(
    parameter int REJECT_THRESHOLD = dwcd_pkg::REJECT_THRESHOLD_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        sample_valid,
    output logic                        sample_stall,
    input  dwcd_pkg::sample_t           sample,
    output logic                        result_valid,
    input  logic                        result_stall,
    output dwcd_pkg::result_t           result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dwcd_pkg::ADDR_W-1:0] paddr,
    input  logic [dwcd_pkg::DATA_W-1:0] pwdata,
    output logic [dwcd_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int TW = dwcd_pkg::TIME_W;
    localparam int WW = dwcd_pkg::WORD_W;
    localparam int CW = dwcd_pkg::CFG_W;
    localparam int NW = dwcd_pkg::CNT_W;
    localparam logic [WW-1:0] MAX32 = '1;
    localparam logic [TW-1:0] MAX40 = '1;

    function automatic logic [WW-1:0] sat_inc(input logic [WW-1:0] v);
        sat_inc = (v != MAX32) ? v + 1'b1 : v;
    endfunction

    // register port
    logic [CW-1:0] period_reg;
    logic [CW-1:0] debounce_reg;
    logic [CW-1:0] window_reg;
    logic [CW-1:0] hold_reg;
    logic [1:0]    reg_index;
    logic          cfg_write;

    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg   <= dwcd_pkg::SAMPLE_PERIOD_RST;
            debounce_reg <= dwcd_pkg::DEBOUNCE_RST;
            window_reg   <= dwcd_pkg::WINDOW_RST;
            hold_reg     <= dwcd_pkg::HOLD_RST;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                dwcd_pkg::REG_SAMPLE_PERIOD: period_reg   <= pwdata[CW-1:0];
                dwcd_pkg::REG_DEBOUNCE:      debounce_reg <= pwdata[CW-1:0];
                dwcd_pkg::REG_WINDOW:        window_reg   <= pwdata[CW-1:0];
                dwcd_pkg::REG_HOLD:          hold_reg     <= pwdata[CW-1:0];
                default:                     period_reg   <= period_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            dwcd_pkg::REG_SAMPLE_PERIOD: prdata = dwcd_pkg::DATA_W'(period_reg);
            dwcd_pkg::REG_DEBOUNCE:      prdata = dwcd_pkg::DATA_W'(debounce_reg);
            dwcd_pkg::REG_WINDOW:        prdata = dwcd_pkg::DATA_W'(window_reg);
            dwcd_pkg::REG_HOLD:          prdata = dwcd_pkg::DATA_W'(hold_reg);
            default:                     prdata = '0;
        endcase
    end

    // state
    dwcd_pkg::state_t  state_reg, state_next;
    logic              level_reg, level_next;
    logic [TW-1:0]     now_reg, now_next;
    logic              seen_reg, seen_next;
    logic              stable_reg, stable_next;
    logic              raw_reg, raw_next;
    logic              cand_active_reg, cand_active_next;
    logic              cand_level_reg, cand_level_next;
    logic [WW-1:0]     cand_age_reg, cand_age_next;
    logic [NW-1:0]     fill_reg, fill_next;
    logic [NW-1:0]     hits_reg, hits_next;
    logic [WW-1:0]     last_width_reg, last_width_next;
    logic [TW-1:0]     chatter_end_reg, chatter_end_next;
    logic [TW-1:0]     last_accept_reg, last_accept_next;
    logic [TW-1:0]     first_time_reg, first_time_next;
    logic [WW-1:0]     accepts_reg, accepts_next;
    logic [WW-1:0]     rejects_reg, rejects_next;
    logic [WW-1:0]     chatters_reg, chatters_next;
    logic              was_chat_reg, was_chat_next;
    logic              edge_reg, edge_next;
    logic              rej_reg, rej_next;
    logic              started_reg, started_next;
    logic              accepted_reg, accepted_next;
    logic              launch_reg, launch_next;
    logic              out_valid_reg, out_valid_next;
    dwcd_pkg::result_t out_data_reg, out_data_next;
    logic              shift;

    // cell row
    logic [TW-1:0]  t_q   [REJECT_THRESHOLD];
    dwcd_pkg::tok_t tok_q [REJECT_THRESHOLD];
    dwcd_pkg::tok_t tok_head;

    always_comb
    begin
        tok_head.valid = launch_reg;
        tok_head.left  = fill_reg;
        tok_head.hits  = '0;
    end

    for (genvar i = 0; i < REJECT_THRESHOLD; i++)
    begin : g_cell
        dwcd_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .shift   (shift),
            .t_in    ((i == 0) ? now_reg : t_q[(i == 0) ? 0 : i - 1]),
            .t_out   (t_q[i]),
            .tok_in  ((i == 0) ? tok_head : tok_q[(i == 0) ? 0 : i - 1]),
            .tok_out (tok_q[i]),
            .now     (now_reg),
            .window  (window_reg)
        );
    end

    // sequencer
    logic [WW:0]   age_sum;
    logic [WW-1:0] age_new;
    logic [TW:0]   end_sum;
    logic [TW-1:0] since;

    always_comb
    begin
        state_next       = state_reg;
        level_next       = level_reg;
        now_next         = now_reg;
        seen_next        = seen_reg;
        stable_next      = stable_reg;
        raw_next         = raw_reg;
        cand_active_next = cand_active_reg;
        cand_level_next  = cand_level_reg;
        cand_age_next    = cand_age_reg;
        fill_next        = fill_reg;
        hits_next        = hits_reg;
        last_width_next  = last_width_reg;
        chatter_end_next = chatter_end_reg;
        last_accept_next = last_accept_reg;
        first_time_next  = first_time_reg;
        accepts_next     = accepts_reg;
        rejects_next     = rejects_reg;
        chatters_next    = chatters_reg;
        was_chat_next    = was_chat_reg;
        edge_next        = edge_reg;
        rej_next         = rej_reg;
        started_next     = started_reg;
        accepted_next    = accepted_reg;
        launch_next      = 1'b0;
        out_valid_next   = out_valid_reg && result_stall;
        out_data_next    = out_data_reg;
        shift            = 1'b0;
        sample_stall     = 1'b1;

        age_sum = (cand_active_reg && (cand_level_reg == level_reg))
                  ? {1'b0, cand_age_reg} + (WW + 1)'(period_reg)
                  : (WW + 1)'(period_reg);
        age_new = age_sum[WW] ? MAX32 : age_sum[WW-1:0];
        end_sum = {1'b0, now_reg} + (TW + 1)'(hold_reg);
        since   = (accepts_reg != '0) ? last_accept_reg : first_time_reg;

        case (state_reg)
            dwcd_pkg::ST_IDLE:
            begin
                sample_stall = 1'b0;
                if (sample_valid)
                begin
                    level_next = sample.level_in;
                    now_next   = sample.now_ms;
                    state_next = dwcd_pkg::ST_EVAL;
                end
            end
            dwcd_pkg::ST_EVAL:
            begin
                edge_next     = 1'b0;
                rej_next      = 1'b0;
                started_next  = 1'b0;
                accepted_next = 1'b0;
                state_next    = dwcd_pkg::ST_OUT;
                if (!seen_reg)
                begin
                    seen_next       = 1'b1;
                    stable_next     = level_reg;
                    raw_next        = level_reg;
                    cand_level_next = level_reg;
                    first_time_next = now_reg;
                end
                else
                begin
                    raw_next  = level_reg;
                    edge_next = level_reg != raw_reg;
                    if (level_reg == stable_reg)
                    begin
                        if (cand_active_reg)
                        begin
                            shift           = 1'b1;
                            launch_next     = 1'b1;
                            fill_next       = (fill_reg < NW'(REJECT_THRESHOLD))
                                              ? fill_reg + 1'b1 : fill_reg;
                            last_width_next = cand_age_reg;
                            rejects_next    = sat_inc(rejects_reg);
                            rej_next        = 1'b1;
                            was_chat_next   = chatter_end_reg > now_reg;
                            state_next      = dwcd_pkg::ST_COUNT;
                        end
                        cand_active_next = 1'b0;
                        cand_level_next  = stable_reg;
                        cand_age_next    = '0;
                    end
                    else
                    begin
                        cand_level_next = level_reg;
                        if (age_new >= WW'(debounce_reg))
                        begin
                            stable_next      = level_reg;
                            cand_active_next = 1'b0;
                            cand_age_next    = '0;
                            last_accept_next = now_reg;
                            hits_next        = '0;
                            fill_next        = '0;
                            accepts_next     = sat_inc(accepts_reg);
                            accepted_next    = 1'b1;
                        end
                        else
                        begin
                            cand_active_next = 1'b1;
                            cand_age_next    = age_new;
                        end
                    end
                end
            end
            dwcd_pkg::ST_COUNT:
            begin
                if (tok_q[REJECT_THRESHOLD-1].valid)
                begin
                    hits_next = tok_q[REJECT_THRESHOLD-1].hits;
                    if (tok_q[REJECT_THRESHOLD-1].hits >= NW'(REJECT_THRESHOLD))
                    begin
                        chatter_end_next = end_sum[TW] ? MAX40 : end_sum[TW-1:0];
                        if (!was_chat_reg)
                        begin
                            chatters_next = sat_inc(chatters_reg);
                            started_next  = 1'b1;
                        end
                    end
                    state_next = dwcd_pkg::ST_OUT;
                end
            end
            dwcd_pkg::ST_OUT:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next                     = 1'b1;
                    out_data_next.stable_level         = stable_reg;
                    out_data_next.raw_toggle           = edge_reg;
                    out_data_next.pulse_dropped        = rej_reg;
                    out_data_next.chatter_begun        = started_reg;
                    out_data_next.level_changed        = accepted_reg;
                    out_data_next.chattering           = chatter_end_reg > now_reg;
                    out_data_next.transition_age_ms    = (now_reg >= since)
                                                         ? now_reg - since : '0;
                    out_data_next.rejections_in_window = hits_reg;
                    out_data_next.last_reject_width_ms = last_width_reg;
                    out_data_next.accepted_count       = accepts_reg;
                    out_data_next.rejected_count       = rejects_reg;
                    out_data_next.chatter_count        = chatters_reg;
                    state_next                         = dwcd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dwcd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= dwcd_pkg::ST_IDLE;
            seen_reg        <= 1'b0;
            stable_reg      <= 1'b0;
            raw_reg         <= 1'b0;
            cand_active_reg <= 1'b0;
            cand_level_reg  <= 1'b0;
            cand_age_reg    <= '0;
            fill_reg        <= '0;
            hits_reg        <= '0;
            last_width_reg  <= '0;
            chatter_end_reg <= '0;
            last_accept_reg <= '0;
            first_time_reg  <= '0;
            accepts_reg     <= '0;
            rejects_reg     <= '0;
            chatters_reg    <= '0;
            was_chat_reg    <= 1'b0;
            edge_reg        <= 1'b0;
            rej_reg         <= 1'b0;
            started_reg     <= 1'b0;
            accepted_reg    <= 1'b0;
            launch_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            seen_reg        <= seen_next;
            stable_reg      <= stable_next;
            raw_reg         <= raw_next;
            cand_active_reg <= cand_active_next;
            cand_level_reg  <= cand_level_next;
            cand_age_reg    <= cand_age_next;
            fill_reg        <= fill_next;
            hits_reg        <= hits_next;
            last_width_reg  <= last_width_next;
            chatter_end_reg <= chatter_end_next;
            last_accept_reg <= last_accept_next;
            first_time_reg  <= first_time_next;
            accepts_reg     <= accepts_next;
            rejects_reg     <= rejects_next;
            chatters_reg    <= chatters_next;
            was_chat_reg    <= was_chat_next;
            edge_reg        <= edge_next;
            rej_reg         <= rej_next;
            started_reg     <= started_next;
            accepted_reg    <= accepted_next;
            launch_reg      <= launch_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg    <= level_next;
        now_reg      <= now_next;
        out_data_reg <= out_data_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

// ===== rtl/dwcd_checker.sv =====
`timescale 1ns / 1ps
// dwcd_checker: port level checks of debounce_with_chatter_detect, bound to the top level
// depends on dwcd_pkg

module dwcd_checker
#(
    parameter int REJECT_THRESHOLD = dwcd_pkg::REJECT_THRESHOLD_DEF
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_stall,
    input dwcd_pkg::result_t result
);

    // stalled beat stays
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result beat dropped under stall");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result beat changed under stall");

    a_hits_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.rejections_in_window <= dwcd_pkg::CNT_W'(REJECT_THRESHOLD))
        else $error("rejection count beyond ring size");

    a_accept_clears: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.level_changed
        |-> result.rejections_in_window == '0 && !result.pulse_dropped)
        else $error("accepted change kept rejections");

endmodule

bind debounce_with_chatter_detect dwcd_checker
#(
    .REJECT_THRESHOLD (REJECT_THRESHOLD)
)
u_dwcd_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for debounce_with_chatter_detect, with its own debounce predictor
// queue fed driver, checking monitor and apb register writes; depends on dwcd_pkg and the rtl

module tb_top;

    localparam int          REJ_THR       = dwcd_pkg::REJECT_THRESHOLD_DEF;
    localparam int          SETTLE_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int          TW            = dwcd_pkg::TIME_W;
    localparam int          WW            = dwcd_pkg::WORD_W;
    localparam int          CW            = dwcd_pkg::CFG_W;

    logic                          clk;
    logic                          rst_n        = 1'b0;
    logic                          sample_valid = 1'b0;
    logic                          sample_stall;
    dwcd_pkg::sample_t             sample       = '0;
    logic                          result_valid;
    logic                          result_stall = 1'b0;
    dwcd_pkg::result_t             result;
    logic                          psel         = 1'b0;
    logic                          penable      = 1'b0;
    logic                          pwrite       = 1'b0;
    logic [dwcd_pkg::ADDR_W-1:0]   paddr        = '0;
    logic [dwcd_pkg::DATA_W-1:0]   pwdata       = '0;
    logic [dwcd_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    // register copies
    logic [CW-1:0] cfg_period   = dwcd_pkg::SAMPLE_PERIOD_RST;
    logic [CW-1:0] cfg_debounce = dwcd_pkg::DEBOUNCE_RST;
    logic [CW-1:0] cfg_window   = dwcd_pkg::WINDOW_RST;
    logic [CW-1:0] cfg_hold     = dwcd_pkg::HOLD_RST;

    // predictor state
    bit            primed      = 1'b0;
    bit            settled_lvl = 1'b0;
    bit            raw_lvl     = 1'b0;
    bit            pend_on     = 1'b0;
    bit            pend_lvl    = 1'b0;
    logic [WW-1:0] pend_age    = '0;
    logic [TW-1:0] reject_stamp [REJ_THR];
    int unsigned   stamp_fill  = 0;
    int unsigned   stamp_wr    = 0;
    int unsigned   hit_total   = 0;
    logic [WW-1:0] reject_width = '0;
    logic [TW-1:0] hold_until  = '0;
    logic [TW-1:0] accept_t    = '0;
    logic [TW-1:0] start_t     = '0;
    logic [WW-1:0] n_accepts   = '0;
    logic [WW-1:0] n_rejects   = '0;
    logic [WW-1:0] n_chatters  = '0;

    dwcd_pkg::sample_t pending_samples [$];
    dwcd_pkg::result_t expected_results [$];
    int unsigned       mismatch_count = 0;
    int unsigned       beat_count     = 0;
    int unsigned       cycle_count    = 0;
    int unsigned       queued_count   = 0;
    bit                gaps_on        = 1'b1;
    logic [TW-1:0]     gen_now        = '0;
    bit                gen_lvl        = 1'b0;

    debounce_with_chatter_detect dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [WW-1:0] sat_inc(input logic [WW-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    task automatic debounce_predict(input dwcd_pkg::sample_t s, output dwcd_pkg::result_t r);
        bit            lvl;
        bit            raw_flip;
        bit            dropped;
        bit            chat_new;
        bit            took;
        bit            was_holding;
        logic [TW-1:0] now_t;
        logic [TW-1:0] since;
        logic [WW:0]   age_sum;
        logic [TW:0]   hold_sum;
        lvl = s.level_in;
        now_t = s.now_ms;
        raw_flip = 1'b0;
        dropped = 1'b0;
        chat_new = 1'b0;
        took = 1'b0;
        if (!primed)
        begin
            primed = 1'b1;
            settled_lvl = lvl;
            raw_lvl = lvl;
            pend_lvl = lvl;
            start_t = now_t;
        end
        else
        begin
            if (lvl != raw_lvl)
            begin
                raw_lvl = lvl;
                raw_flip = 1'b1;
            end
            if (lvl == settled_lvl)
            begin
                if (pend_on)
                begin
                    was_holding = hold_until > now_t;
                    reject_stamp[stamp_wr] = now_t;
                    stamp_wr = (stamp_wr + 1) % REJ_THR;
                    if (stamp_fill < REJ_THR)
                        stamp_fill++;
                    hit_total = 0;
                    for (int i = 0; i < stamp_fill; i++)
                    begin
                        if (now_t >= reject_stamp[i]
                            && (now_t - reject_stamp[i]) <= TW'(cfg_window))
                            hit_total++;
                    end
                    reject_width = pend_age;
                    n_rejects = sat_inc(n_rejects);
                    dropped = 1'b1;
                    if (hit_total >= REJ_THR)
                    begin
                        hold_sum = {1'b0, now_t} + (TW + 1)'(cfg_hold);
                        if (!was_holding)
                        begin
                            n_chatters = sat_inc(n_chatters);
                            chat_new = 1'b1;
                        end
                        hold_until = hold_sum[TW] ? '1 : hold_sum[TW-1:0];
                    end
                end
                pend_on = 1'b0;
                pend_lvl = settled_lvl;
                pend_age = '0;
            end
            else
            begin
                if (!pend_on || pend_lvl != lvl)
                begin
                    pend_on = 1'b1;
                    pend_lvl = lvl;
                    pend_age = WW'(cfg_period);
                end
                else
                begin
                    age_sum = {1'b0, pend_age} + (WW + 1)'(cfg_period);
                    pend_age = age_sum[WW] ? '1 : age_sum[WW-1:0];
                end
                if (pend_age >= WW'(cfg_debounce))
                begin
                    settled_lvl = lvl;
                    pend_on = 1'b0;
                    pend_age = '0;
                    accept_t = now_t;
                    hit_total = 0;
                    stamp_fill = 0;
                    stamp_wr = 0;
                    n_accepts = sat_inc(n_accepts);
                    took = 1'b1;
                end
            end
        end
        since = (n_accepts != 0) ? accept_t : start_t;
        r.stable_level = settled_lvl;
        r.raw_toggle = raw_flip;
        r.pulse_dropped = dropped;
        r.chatter_begun = chat_new;
        r.level_changed = took;
        r.chattering = hold_until > now_t;
        r.transition_age_ms = (now_t >= since) ? now_t - since : '0;
        r.rejections_in_window = hit_total[dwcd_pkg::CNT_W-1:0];
        r.last_reject_width_ms = reject_width;
        r.accepted_count = n_accepts;
        r.rejected_count = n_rejects;
        r.chatter_count = n_chatters;
    endtask

    // driver: one beat offered at a time, held while stalled
    always @(posedge clk)
    begin : sample_driver
        dwcd_pkg::result_t want;
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
            begin
                debounce_predict(sample, want);
                expected_results.push_back(want);
            end
            if (!sample_valid || !sample_stall)
            begin
                if (pending_samples.size() != 0 && !(gaps_on && $urandom_range(99) < 18))
                begin
                    sample <= pending_samples.pop_front();
                    sample_valid <= 1'b1;
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("beat %0d %s: expected %0h, got %0h", beat_count, name, want, got);
        end
    endfunction

    // monitor: compares each result beat with the oldest prediction
    always @(posedge clk)
    begin : result_monitor
        dwcd_pkg::result_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("beat %0d: unexpected result, got %h", beat_count, result);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("stable_level", 64'(want.stable_level),
                                64'(result.stable_level));
                    check_field("raw_toggle", 64'(want.raw_toggle), 64'(result.raw_toggle));
                    check_field("pulse_dropped", 64'(want.pulse_dropped),
                                64'(result.pulse_dropped));
                    check_field("chatter_begun", 64'(want.chatter_begun),
                                64'(result.chatter_begun));
                    check_field("level_changed", 64'(want.level_changed),
                                64'(result.level_changed));
                    check_field("chattering", 64'(want.chattering), 64'(result.chattering));
                    check_field("transition_age_ms", 64'(want.transition_age_ms),
                                64'(result.transition_age_ms));
                    check_field("rejections_in_window", 64'(want.rejections_in_window),
                                64'(result.rejections_in_window));
                    check_field("last_reject_width_ms", 64'(want.last_reject_width_ms),
                                64'(result.last_reject_width_ms));
                    check_field("accepted_count", 64'(want.accepted_count),
                                64'(result.accepted_count));
                    check_field("rejected_count", 64'(want.rejected_count),
                                64'(result.rejected_count));
                    check_field("chatter_count", 64'(want.chatter_count),
                                64'(result.chatter_count));
                end
                beat_count++;
            end
            result_stall <= gaps_on && ($urandom_range(99) < 18);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [CW-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            dwcd_pkg::REG_SAMPLE_PERIOD: cfg_period = value;
            dwcd_pkg::REG_DEBOUNCE:      cfg_debounce = value;
            dwcd_pkg::REG_WINDOW:        cfg_window = value;
            dwcd_pkg::REG_HOLD:          cfg_hold = value;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [CW-1:0] period, input logic [CW-1:0] debounce,
                              input logic [CW-1:0] window, input logic [CW-1:0] hold);
        apb_write(dwcd_pkg::REG_SAMPLE_PERIOD, period);
        apb_write(dwcd_pkg::REG_DEBOUNCE, debounce);
        apb_write(dwcd_pkg::REG_WINDOW, window);
        apb_write(dwcd_pkg::REG_HOLD, hold);
    endtask

    function automatic void queue_at(input bit lvl, input logic [TW-1:0] stamp);
        dwcd_pkg::sample_t s;
        s.level_in = lvl;
        s.now_ms = stamp;
        gen_now = stamp;
        pending_samples.push_back(s);
        queued_count++;
    endfunction

    // next uptime: mostly one period on, with jitter, long gaps, backward steps and jumps
    function automatic void queue_sample(input bit lvl);
        int unsigned   roll;
        logic [TW-1:0] stamp;
        roll = $urandom_range(999);
        if (roll < 8)
            stamp = {8'($urandom), $urandom};
        else if (roll < 14)
            stamp = gen_now - TW'($urandom_range(1, 3000));
        else if (roll < 18)
            stamp = '1 - TW'($urandom_range(0, 2000));
        else if (roll < 60)
            stamp = gen_now + TW'($urandom_range(0, 2 * cfg_period + 1));
        else if (roll < 65)
            stamp = gen_now + TW'($urandom_range(0, 100000));
        else
            stamp = gen_now + ((cfg_period == 0) ? TW'($urandom_range(0, 5)) : TW'(cfg_period));
        queue_at(lvl, stamp);
    endfunction

    // short pulses away from the settled level, each followed by a return
    function automatic void bounce_burst(input int unsigned pulses, input int unsigned need);
        int unsigned plen;
        repeat (pulses)
        begin
            if (need == 0)
                plen = $urandom_range(1, 6);
            else if (need > 1)
                plen = $urandom_range(1, need - 1);
            else
                plen = 1;
            repeat (plen) queue_sample(!gen_lvl);
            repeat ($urandom_range(1, 2)) queue_sample(gen_lvl);
        end
    endfunction

    task automatic gen_random(input int unsigned n);
        int unsigned goal;
        int unsigned need;
        int unsigned roll;
        int unsigned hlen;
        goal = queued_count + n;
        while (queued_count < goal)
        begin
            if (cfg_debounce == 0)
                need = 1;
            else if (cfg_period == 0)
                need = 0;
            else
                need = (cfg_debounce + cfg_period - 1) / cfg_period;
            if (need > 30)
                need = 30;
            roll = $urandom_range(99);
            if (roll < 20)
            begin
                repeat ($urandom_range(1, 6)) queue_sample(gen_lvl);
            end
            else if (roll < 50)
            begin
                bounce_burst($urandom_range(1, 6), need);
            end
            else if (roll < 85)
            begin
                bounce_burst($urandom_range(0, 2), need);
                hlen = (need == 0) ? $urandom_range(1, 12) : need + $urandom_range(0, 3);
                repeat (hlen) queue_sample(!gen_lvl);
                if (need != 0)
                    gen_lvl = !gen_lvl;
            end
            else
            begin
                repeat ($urandom_range(1, 8)) queue_sample(1'($urandom_range(0, 1)));
            end
            @(posedge clk);
        end
    endtask

    task automatic drain_and_settle();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || sample_valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // first sample, four quick bounces into chatter, then an accepted fall
        queue_at(1'b1, 40'd1000);
        for (int i = 0; i < 4; i++)
        begin
            queue_at(1'b0, 40'd1010 + 20 * i);
            queue_at(1'b1, 40'd1020 + 20 * i);
        end
        for (int i = 0; i < 5; i++)
            queue_at(1'b0, 40'd1090 + 10 * i);
        // chatter near the top of the uptime range, hold end saturates
        queue_at(1'b1, '1 - 40'd60);
        queue_at(1'b0, '1 - 40'd50);
        queue_at(1'b1, '1 - 40'd40);
        queue_at(1'b0, '1 - 40'd30);
        queue_at(1'b1, '1 - 40'd20);
        queue_at(1'b0, '1 - 40'd10);
        queue_at(1'b1, '1 - 40'd5);
        queue_at(1'b0, '1);
        // uptime wraps back: stale stamps lie in the future
        queue_at(1'b1, 40'd0);
        queue_at(1'b0, 40'd5);
        gen_lvl = 1'b0;
        gen_random(230);
        drain_and_settle();

        set_config(16'd3, 16'd20, 16'd100, 16'd300);
        gen_random(230);
        drain_and_settle();

        set_config(16'd1, 16'd0, 16'd0, 16'd0);
        gen_random(230);
        drain_and_settle();

        set_config(16'd0, 16'd7, 16'hFFFF, 16'hFFFF);
        gen_random(230);
        drain_and_settle();

        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        gen_random(230);
        drain_and_settle();

        // no gaps on either side for this stretch
        gaps_on = 1'b0;
        set_config(16'd7, 16'd30, 16'd200, 16'd1000);
        gen_random(230);
        drain_and_settle();
        gaps_on = 1'b1;

        // sender holds off mid phase until every result is back
        set_config(16'd1, 16'd4, 16'd50, 16'd200);
        gen_random(115);
        drain_and_settle();
        gen_random(115);
        drain_and_settle();

        set_config(16'd5, 16'd12, 16'hFFFF, 16'd0);
        gen_random(230);
        drain_and_settle();

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
